// ===== design/elarx_pkg.sv =====
// Shared codes, action types and controller/datapath interface structs.
package elarx_pkg;

    // Received control codes.
    localparam logic [7:0] ESC_CODE   = 8'h01;
    localparam logic [7:0] BS_CODE    = 8'h08;
    localparam logic [7:0] LF_CODE    = 8'h0a;
    localparam logic [7:0] CR_CODE    = 8'h0d;
    localparam logic [7:0] XON_CODE   = 8'h11;
    localparam logic [7:0] XOFF_CODE  = 8'h13;
    localparam logic [7:0] NUL_CODE   = 8'h00;
    localparam logic [7:0] ESC_OFFSET = 8'h40;

    // Configuration register indexes.
    localparam logic [1:0] REG_BACKSPACE_ENABLE = 2'd0;
    localparam logic [1:0] REG_LF_HANDLING      = 2'd1;
    localparam logic [1:0] REG_BINARY_MODE      = 2'd2;

    // Result kinds.
    localparam logic KIND_LINE_BYTE = 1'b0;
    localparam logic KIND_ERASE     = 1'b1;

    // What an accepted byte causes.
    typedef enum logic [1:0] {
        ACT_DROP  = 2'd0,
        ACT_STORE = 2'd1,
        ACT_FLUSH = 2'd2,
        ACT_ECHO  = 2'd3
    } t_act;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;      // input transaction taken this cycle
        logic rd_en;       // read the next stored byte
        logic load_line;   // move read data into the output register
        logic load_echo;   // load an erase echo into the output register
        logic clear_fill;  // last line byte loaded, empty the store
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        t_act act;         // action for the byte at the input
        logic rd_last;     // read data is the final byte of the line
        logic out_free;    // output register can take a result this cycle
    } t_dp_sts;

endpackage

// ===== design/escaped_line_assembler_rx_core.sv =====
// A byte that ends a line is followed by a store read, then its first line byte enters the output register.
// Throughput: one input byte per cycle while idle; a line flush holds input until its last byte is loaded,
// paced by the single registered read port of the line store (one byte per cycle unless stalled).
// An erase echo holds input until the echo is loaded; result stream stalls lengthen both holds.
// Reset is synchronous, active low: control registers return to defaults; store and data registers are kept.
module escaped_line_assembler_rx_core #(
    parameter int LINE_SIZE = 64
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // Received byte stream.
    input  logic       i_s_tvalid,
    output logic       o_s_tready,
    input  logic [7:0] i_s_tdata,   // [7:0] rx_byte
    input  logic       i_s_tlast,   // chunk_end
    // Result stream.
    output logic       o_m_tvalid,
    input  logic       i_m_tready,
    output logic [7:0] o_m_tdata,   // [7:0] out_byte
    output logic       o_m_tuser,   // [0] result_kind
    output logic       o_m_tlast,   // line_last
    // Configuration writes.
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [1:0] i_cfg_index,
    input  logic       i_cfg_data
);
    elarx_pkg::t_dp_cmd w_cmd;
    elarx_pkg::t_dp_sts w_sts;

    assign o_cfg_ready = 1'b1;

    // Sequencing of accepts, echoes and flushes.
    elarx_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_tvalid),
        .o_in_ready (o_s_tready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    // Decode, store and output path.
    elarx_dp #(
        .LINE_SIZE (LINE_SIZE)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_rx_byte   (i_s_tdata),
        .i_chunk_end (i_s_tlast),
        .i_cfg_we    (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .i_out_ready (i_m_tready),
        .o_out_valid (o_m_tvalid),
        .o_out_byte  (o_m_tdata),
        .o_out_kind  (o_m_tuser),
        .o_out_last  (o_m_tlast)
    );

`ifndef SYNTHESIS
    // An erase echo always carries a zero byte and closes its own result.
    a_echo_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser) |-> (o_m_tlast && o_m_tdata == 8'h00))
        else $error("erase echo malformed");

    // No input transaction is taken while the store is being read out.
    a_no_accept_in_flush: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cmd.rd_en || w_cmd.load_line) |-> !o_s_tready)
        else $error("input accepted during flush");

    // A loaded result is never dropped before the sink takes it.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=> o_m_tvalid)
        else $error("result lost while stalled");
`endif

endmodule

// ===== design/elarx_dp.sv =====
// Datapath: byte decode, line store memory, fill count, read path and output register.
module elarx_dp #(
    parameter int LINE_SIZE = 64
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic [7:0]            i_rx_byte,
    input  logic                  i_chunk_end,
    input  logic                  i_cfg_we,
    input  logic [1:0]            i_cfg_index,
    input  logic                  i_cfg_data,
    input  elarx_pkg::t_dp_cmd    i_cmd,
    output elarx_pkg::t_dp_sts    o_sts,
    input  logic                  i_out_ready,
    output logic                  o_out_valid,
    output logic [7:0]            o_out_byte,
    output logic                  o_out_kind,
    output logic                  o_out_last
);
    localparam int CW = $clog2(LINE_SIZE + 1);
    localparam int AW = (LINE_SIZE > 2) ? $clog2(LINE_SIZE) : 1;
    localparam logic [CW-1:0] FULL_COUNT = CW'(LINE_SIZE);

    // Configuration and control state.
    logic          r_bs_en;
    logic          r_lf_mode;
    logic          r_bin_mode;
    logic          r_esc;
    logic [CW-1:0] r_fill;
    logic [CW-1:0] r_rd_idx;

    // Line store and its registered read port.
    logic [7:0]    r_mem [LINE_SIZE];
    logic [7:0]    r_rd_data;
    logic          r_rd_last;

    // Output register.
    logic          r_out_valid;
    logic [7:0]    r_out_byte;
    logic          r_out_kind;
    logic          r_out_last;

    logic [7:0]    n_byte;
    logic [CW-1:0] n_fill_inc;
    elarx_pkg::t_act n_act;
    logic          n_esc_set;

    // Decode the byte at the input into an action and the value to store.
    always_comb begin
        n_byte     = i_rx_byte;
        n_act      = elarx_pkg::ACT_DROP;
        n_esc_set  = 1'b0;
        n_fill_inc = r_fill + CW'(1);
        if (r_esc) begin
            n_byte = i_rx_byte - elarx_pkg::ESC_OFFSET;
            n_act  = elarx_pkg::ACT_STORE;
        end else if (i_rx_byte == elarx_pkg::ESC_CODE) begin
            n_esc_set = 1'b1;
        end else if (i_rx_byte == elarx_pkg::BS_CODE) begin
            if (r_bs_en && (r_fill != '0)) begin
                n_act = elarx_pkg::ACT_ECHO;
            end
        end else if (i_rx_byte == elarx_pkg::XON_CODE || i_rx_byte == elarx_pkg::XOFF_CODE ||
                     i_rx_byte == elarx_pkg::NUL_CODE) begin
            n_act = elarx_pkg::ACT_DROP;
        end else if (!r_lf_mode) begin
            if (i_rx_byte == elarx_pkg::LF_CODE) begin
                n_byte = elarx_pkg::CR_CODE;
                n_act  = elarx_pkg::ACT_STORE;
            end else if (i_rx_byte != elarx_pkg::CR_CODE) begin
                n_act = elarx_pkg::ACT_STORE;
            end
        end else begin
            if (i_rx_byte != elarx_pkg::LF_CODE) begin
                n_act = elarx_pkg::ACT_STORE;
            end
        end
        // A stored byte ends the line on CR, on a full store or at a binary chunk end.
        if (n_act == elarx_pkg::ACT_STORE) begin
            if (n_byte == elarx_pkg::CR_CODE || n_fill_inc == FULL_COUNT ||
                (r_bin_mode && i_chunk_end)) begin
                n_act = elarx_pkg::ACT_FLUSH;
            end
        end
    end

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bs_en    <= 1'b1;
            r_lf_mode  <= 1'b0;
            r_bin_mode <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                elarx_pkg::REG_BACKSPACE_ENABLE: r_bs_en    <= i_cfg_data;
                elarx_pkg::REG_LF_HANDLING:      r_lf_mode  <= i_cfg_data;
                elarx_pkg::REG_BINARY_MODE:      r_bin_mode <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Escape flag, fill count and read index.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_esc    <= 1'b0;
            r_fill   <= '0;
            r_rd_idx <= '0;
        end else begin
            if (i_cmd.accept) begin
                r_esc <= n_esc_set;
                if (n_act == elarx_pkg::ACT_STORE || n_act == elarx_pkg::ACT_FLUSH) begin
                    r_fill <= n_fill_inc;
                end else if (n_act == elarx_pkg::ACT_ECHO) begin
                    r_fill <= r_fill - CW'(1);
                end
            end
            if (i_cmd.clear_fill) begin
                r_fill   <= '0;
                r_rd_idx <= '0;
            end else if (i_cmd.rd_en) begin
                r_rd_idx <= r_rd_idx + CW'(1);
            end
        end
    end

    // Line store: one write port at the fill position, one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept &&
            (n_act == elarx_pkg::ACT_STORE || n_act == elarx_pkg::ACT_FLUSH)) begin
            r_mem[r_fill[AW-1:0]] <= n_byte;
        end
        if (i_cmd.rd_en) begin
            r_rd_data <= r_mem[r_rd_idx[AW-1:0]];
            r_rd_last <= (r_rd_idx == r_fill - CW'(1));
        end
    end

    // Output register, freed when the downstream side takes the transaction.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_line || i_cmd.load_echo) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_echo) begin
            r_out_byte <= 8'h00;
            r_out_kind <= elarx_pkg::KIND_ERASE;
            r_out_last <= 1'b1;
        end else if (i_cmd.load_line) begin
            r_out_byte <= r_rd_data;
            r_out_kind <= elarx_pkg::KIND_LINE_BYTE;
            r_out_last <= r_rd_last;
        end
    end

    assign o_sts.act      = n_act;
    assign o_sts.rd_last  = r_rd_last;
    assign o_sts.out_free = !r_out_valid || i_out_ready;

    assign o_out_valid = r_out_valid;
    assign o_out_byte  = r_out_byte;
    assign o_out_kind  = r_out_kind;
    assign o_out_last  = r_out_last;

endmodule

// ===== design/elarx_ctrl.sv =====
// Controller: accepts bytes, sequences erase echoes and line flushes.
module elarx_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  elarx_pkg::t_dp_sts i_sts,
    output elarx_pkg::t_dp_cmd o_cmd
);
    typedef enum logic [1:0] {
        ST_IDLE    = 2'd0,
        ST_ECHO    = 2'd1,
        ST_FL_READ = 2'd2,
        ST_FL_SEND = 2'd3
    } t_state;

    t_state r_state;
    t_state n_state;

    // Next state and datapath commands.
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    case (i_sts.act)
                        elarx_pkg::ACT_ECHO:  n_state = ST_ECHO;
                        elarx_pkg::ACT_FLUSH: n_state = ST_FL_READ;
                        default:              n_state = ST_IDLE;
                    endcase
                end
            end
            ST_ECHO: begin
                if (i_sts.out_free) begin
                    o_cmd.load_echo = 1'b1;
                    n_state         = ST_IDLE;
                end
            end
            ST_FL_READ: begin
                o_cmd.rd_en = 1'b1;
                n_state     = ST_FL_SEND;
            end
            ST_FL_SEND: begin
                // Hand over the read byte and fetch the next one in the same cycle.
                if (i_sts.out_free) begin
                    o_cmd.load_line = 1'b1;
                    if (i_sts.rd_last) begin
                        o_cmd.clear_fill = 1'b1;
                        n_state          = ST_IDLE;
                    end else begin
                        o_cmd.rd_en = 1'b1;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == ST_IDLE);

endmodule
